>>> hdl/assert_macros.svh
// Assertion macros shared by the converter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hdl/hr8c_pkg.sv
// Types and constants for the hex real to binary64 converter
package hr8c_pkg;
    localparam int unsigned WORD_W     = 64;
    localparam int unsigned FRAC_W     = 56;
    localparam int unsigned LZ_W       = 6;
    localparam int unsigned BEXP_W     = 11;
    localparam int unsigned HEXP_W     = 7;
    localparam int unsigned MANT_W     = 52;
    localparam logic [12:0] IEEE_BIAS_M1 = 13'd1022;   // 1023 - 1
    localparam logic [12:0] HEX_BIAS_X4  = 13'd256;    // 4 * 64

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [FRAC_W-1:0] t_frac;

    // Stage 1 to stage 2 payload
    typedef struct packed {
        logic              sign;
        logic              zero;
        logic [HEXP_W-1:0] hexp;
        logic [LZ_W-1:0]   lz;
        t_frac             frac;
    } t_s1;

    // Stage 2 to stage 3 payload
    typedef struct packed {
        logic              sign;
        logic              zero;
        logic [BEXP_W-1:0] bexp;
        t_frac             norm;
    } t_s2;
endpackage

>>> hdl/hr8c_lzc.sv
// Stage 1: split the word and count leading zeros of the fraction
module hr8c_lzc (
    input  logic          i_clk,
    input  logic          i_en,
    input  hr8c_pkg::t_word i_word,
    output hr8c_pkg::t_s1 o_s1
);
    import hr8c_pkg::*;

    t_s1         n_s1;
    logic [LZ_W-1:0] w_lz;
    t_frac       w_frac;

    // Priority search from the top fraction bit
    always_comb begin
        w_frac = i_word[FRAC_W-1:0];
        w_lz   = LZ_W'(FRAC_W - 1);
        for (int k = 0; k < FRAC_W; k++) begin
            if (w_frac[k]) begin
                w_lz = LZ_W'(FRAC_W - 1 - k);
            end
        end
        n_s1.sign = i_word[WORD_W-1];
        n_s1.hexp = i_word[WORD_W-2:FRAC_W];
        n_s1.zero = (w_frac == '0);
        n_s1.lz   = w_lz;
        n_s1.frac = w_frac;
    end

    // Advance when the pipe moves
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_s1 <= n_s1;
        end
    end
endmodule

>>> hdl/hr8c_norm.sv
// Stage 2: shift the fraction up and rebias the exponent
module hr8c_norm (
    input  logic          i_clk,
    input  logic          i_en,
    input  hr8c_pkg::t_s1 i_s1,
    output hr8c_pkg::t_s2 o_s2
);
    import hr8c_pkg::*;

    t_s2         n_s2;
    logic [12:0] w_exp;

    // 4*hexp - 256 - 1 - lz + 1023
    always_comb begin
        w_exp = {4'd0, i_s1.hexp, 2'b00} + IEEE_BIAS_M1 - HEX_BIAS_X4
              - {7'd0, i_s1.lz};
        n_s2.sign = i_s1.sign;
        n_s2.zero = i_s1.zero;
        n_s2.bexp = w_exp[BEXP_W-1:0];
        n_s2.norm = i_s1.frac << i_s1.lz;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_s2 <= n_s2;
        end
    end
endmodule

>>> hdl/hr8c_round.sv
// Stage 3: round to 52 bits, nearest even, and pack the result
module hr8c_round (
    input  logic            i_clk,
    input  logic            i_en,
    input  hr8c_pkg::t_s2   i_s2,
    output hr8c_pkg::t_word o_word
);
    import hr8c_pkg::*;

    t_word       n_word;
    logic [52:0] w_keep;
    logic [53:0] w_sum;
    logic [2:0]  w_rem;
    logic        w_up;
    logic [BEXP_W-1:0] w_exp;

    always_comb begin
        // Keep the leading one so a rounding carry shows up in the top bit
        w_keep = i_s2.norm[FRAC_W-1:3];
        w_rem  = i_s2.norm[2:0];
        w_up   = (w_rem > 3'd4) || ((w_rem == 3'd4) && w_keep[0]);
        w_sum  = {1'b0, w_keep} + {53'd0, w_up};
        w_exp  = i_s2.bexp;
        // Carry out of the rounding bumps the exponent; fraction becomes zero
        if (w_sum[53]) begin
            w_exp  = i_s2.bexp + BEXP_W'(1);
        end
        if (i_s2.zero) begin
            n_word = {i_s2.sign, 63'd0};
        end else begin
            n_word = {i_s2.sign, w_exp, w_sum[53] ? w_sum[MANT_W:1] : w_sum[MANT_W-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_word <= n_word;
        end
    end
endmodule

>>> hdl/hex_real8_to_ieee_double_core.sv
// Top level: three-stage hex real to IEEE binary64 converter
//
// Converts one 8-byte base-16 real word per transaction to a binary64
// bit pattern. Input channel: i_valid / o_ready with i_hex_real_word.
// Output channel: o_valid / i_ready with o_ieee_double_word.
// Path: an accepted word passes the stage 1, stage 2 and stage 3
// registers in turn, and o_valid rises once stage 3 holds it.
// Throughput: one transaction per cycle while the receiver keeps i_ready
// high; stage depth is set by the leading-zero search, the 56-bit
// normalizing shift and the 53-bit rounding increment, one per stage.
// Each stage carries its own valid bit. A stage loads whenever it is
// empty or the stage after it loads, so a stalled receiver holds the
// pipe full and no transaction is dropped or repeated; o_ready falls
// only once all three stages hold data and the receiver is stalled.
// Reset clears all valid bits; payload registers are not reset.
module hex_real8_to_ieee_double_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_hex_real_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_ieee_double_word
);
    import hr8c_pkg::*;
    `include "assert_macros.svh"

    logic [2:0] r_vld;
    logic [2:0] n_vld;
    logic       w_en1, w_en2, w_en3;
    t_s1        w_s1;
    t_s2        w_s2;

    // Stage enables: load when empty or downstream moves
    assign w_en3   = !r_vld[2] || i_ready;
    assign w_en2   = !r_vld[1] || w_en3;
    assign w_en1   = !r_vld[0] || w_en2;
    assign o_ready = w_en1;
    assign o_valid = r_vld[2];

    always_comb begin
        n_vld = r_vld;
        if (w_en1) n_vld[0] = i_valid;
        if (w_en2) n_vld[1] = r_vld[0];
        if (w_en3) n_vld[2] = r_vld[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    hr8c_lzc u_lzc (
        .i_clk  (i_clk),
        .i_en   (w_en1),
        .i_word (i_hex_real_word),
        .o_s1   (w_s1)
    );

    hr8c_norm u_norm (
        .i_clk (i_clk),
        .i_en  (w_en2),
        .i_s1  (w_s1),
        .o_s2  (w_s2)
    );

    hr8c_round u_round (
        .i_clk  (i_clk),
        .i_en   (w_en3),
        .i_s2   (w_s2),
        .o_word (o_ieee_double_word)
    );

    // A stalled output keeps its valid bit
    `ASSERT_CLK(a_hold_out, i_clk, i_rst_n, (o_valid && !i_ready) |=> o_valid, "output lost on stall")
    // Ready drops only when every stage is full
    `ASSERT_CLK(a_ready_full, i_clk, i_rst_n, !o_ready |-> (r_vld == 3'b111), "ready low with a bubble")
    // An accepted input reaches stage one
    `ASSERT_CLK(a_in_lands, i_clk, i_rst_n, (i_valid && o_ready) |=> r_vld[0], "input not captured")
endmodule
